@@ src/assert_macros.svh @@
// Assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`endif

@@ src/scrw_pkg.sv @@
`default_nettype none
package scrw_pkg;

  localparam int unsigned NumContexts = 256;
  localparam int unsigned IdxW = $clog2(NumContexts);
  localparam int unsigned WinSize = 64;

  typedef enum logic [1:0] {
    FUNC_ESTABLISH = 2'd0,
    FUNC_VALIDATE  = 2'd1,
    FUNC_DESTROY   = 2'd2,
    FUNC_UNUSED    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_BELOW   = 3'd3,
    ST_REPLAY  = 3'd4
  } status_e;

  localparam logic [1:0] SvcNone  = 2'd1;
  localparam logic [1:0] SvcInteg = 2'd2;
  localparam logic [1:0] SvcPriv  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] handle;
    logic [31:0] seq_num;
    logic [1:0]  req_service;
    logic        conf_flag;
    logic        integ_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  granted_service;
    logic [31:0] stored_handle;
  } rsp_t;

  // Command passed from the front end to the back end
  typedef struct packed {
    req_t            req;
    logic            found;
    logic [IdxW-1:0] slot;
  } cmd_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SCAN,
    FS_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_EXEC,
    BS_OUT
  } back_state_e;

endpackage
`default_nettype wire

@@ src/scrw_front.sv @@
`default_nettype none
// Front end: walks the slot table for a free slot or a matching handle
module scrw_front import scrw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire req_t            in_data_i,
  // table view kept by the back end
  input  wire logic [NumContexts-1:0] slot_valid_i,
  output logic [IdxW-1:0]      tag_addr_o,
  input  wire logic [31:0]     tag_data_i,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_full_i,
  output cmd_t                 cmd_o,
  input  wire logic            back_busy_i
);

  front_state_e state_q, state_d;
  req_t            req_q;
  logic [IdxW:0]   idx_q, idx_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic            rd_pend_q;
  logic [31:0]     h_cmp;
  logic            take;

  // handle compared as stored on establish is irrelevant; lookups use raw handle
  assign h_cmp = req_q.handle;
  assign take = (state_q == FS_IDLE) && in_valid_i && !back_busy_i;
  assign in_stall_o = !((state_q == FS_IDLE) && !back_busy_i);
  assign tag_addr_o = idx_q[IdxW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    found_d = found_q;
    slot_d = slot_q;
    unique case (state_q)
      FS_IDLE: begin
        if (take) begin
          state_d = FS_SCAN;
          idx_d = '0;
          found_d = 1'b0;
        end
      end
      FS_SCAN: begin
        if (req_q.func == FUNC_ESTABLISH) begin
          // free slot search over valid flags, one slot a cycle
          if (!slot_valid_i[idx_q[IdxW-1:0]]) begin
            found_d = 1'b1;
            slot_d = idx_q[IdxW-1:0];
            state_d = FS_PUSH;
          end else if (idx_q == (IdxW+1)'(NumContexts - 1)) begin
            state_d = FS_PUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (req_q.func == FUNC_UNUSED) begin
          state_d = FS_PUSH;
        end else if (rd_pend_q) begin
          // tag read for idx_q-1 returned
          if (slot_valid_i[slot_q] && tag_data_i == h_cmp) begin
            found_d = 1'b1;
            state_d = FS_PUSH;
          end else if (idx_q == (IdxW+1)'(NumContexts)) begin
            state_d = FS_PUSH;
          end else begin
            slot_d = idx_q[IdxW-1:0];
            idx_d = idx_q + 1'b1;
          end
        end else begin
          slot_d = idx_q[IdxW-1:0];
          idx_d = idx_q + 1'b1;
        end
      end
      FS_PUSH: begin
        if (!cmd_full_i) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_valid_o = (state_q == FS_PUSH);
    cmd_o.req = req_q;
    cmd_o.found = found_q;
    cmd_o.slot = slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      idx_q <= '0;
      found_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      found_q <= found_d;
      rd_pend_q <= (state_q == FS_SCAN) && (state_d == FS_SCAN)
                   && (req_q.func != FUNC_ESTABLISH);
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (take) req_q <= in_data_i;
  end

endmodule
`default_nettype wire

@@ src/scrw_back.sv @@
`default_nettype none
// Back end: executes commands against the context memory
module scrw_back import scrw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_full_o,
  input  wire cmd_t            cmd_i,
  output logic [NumContexts-1:0] slot_valid_o,
  input  wire logic [IdxW-1:0] tag_addr_i,
  output logic [31:0]          tag_data_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output rsp_t                 out_data_o
);

  back_state_e state_q, state_d;
  cmd_t  cmd_q;
  logic  [NumContexts-1:0] valid_q;
  logic  [31:0] tag_mem [NumContexts];
  logic  [97:0] ctx_mem [NumContexts];   // {service, bottom, bitmap}
  logic  [97:0] ctx_rd_q;
  rsp_t  rsp_q;
  logic  [1:0]  svc;
  logic  [31:0] low, off, sh, new_low;
  logic  [63:0] bmp, bmp_sh, bit_m;
  logic  [97:0] ctx_wr;
  logic         ctx_we;
  rsp_t         rsp_d;
  logic  [31:0] new_h;

  assign slot_valid_o = valid_q;
  assign cmd_full_o = (state_q != BS_IDLE);
  assign busy_o = (state_q != BS_IDLE);
  assign out_valid_o = (state_q == BS_OUT);
  assign out_data_o = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: if (cmd_valid_i) state_d = BS_READ;
      BS_READ: state_d = BS_EXEC;
      BS_EXEC: state_d = BS_OUT;
      BS_OUT:  if (!out_stall_i) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  // window update and response on the read context entry
  always_comb begin
    svc = ctx_rd_q[97:96];
    low = ctx_rd_q[95:64];
    bmp = ctx_rd_q[63:0];
    off = cmd_q.req.seq_num - low;
    sh = off - 32'(WinSize);
    new_low = low;
    bmp_sh = bmp;
    if (off > 32'(WinSize)) begin
      bmp_sh = (sh >= 32'(WinSize)) ? 64'd0 : (bmp >> sh[5:0]);
      new_low = cmd_q.req.seq_num - 32'(WinSize);
      off = 32'(WinSize);
    end
    bit_m = 64'd1 << 6'(off - 32'd1);
    new_h = (cmd_q.req.handle == 32'd0) ? 32'd1 : cmd_q.req.handle;
    rsp_d = '0;
    rsp_d.status = ST_UNKNOWN;
    ctx_we = 1'b0;
    ctx_wr = {svc, new_low, bmp_sh | bit_m};
    case (cmd_q.req.func)
      FUNC_ESTABLISH: begin
        if (cmd_q.found) begin
          rsp_d.status = ST_OK;
          rsp_d.stored_handle = new_h;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      FUNC_VALIDATE: begin
        if (cmd_q.found) begin
          if (cmd_q.req.seq_num <= low) begin
            rsp_d.status = ST_BELOW;
          end else if ((bmp_sh & bit_m) != 64'd0) begin
            rsp_d.status = ST_REPLAY;
          end else begin
            rsp_d.status = ST_OK;
            rsp_d.granted_service = (cmd_q.req.req_service > svc) ? svc
                                    : cmd_q.req.req_service;
            ctx_we = 1'b1;
          end
        end
      end
      FUNC_DESTROY: if (cmd_q.found) rsp_d.status = ST_OK;
      default: rsp_d.status = ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BS_EXEC && cmd_q.found) begin
        if (cmd_q.req.func == FUNC_ESTABLISH) valid_q[cmd_q.slot] <= 1'b1;
        if (cmd_q.req.func == FUNC_DESTROY) valid_q[cmd_q.slot] <= 1'b0;
      end
    end
  end

  // memories and payload
  always_ff @(posedge clk_i) begin
    if (state_q == BS_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == BS_EXEC) rsp_q <= rsp_d;
    ctx_rd_q <= ctx_mem[cmd_q.slot];
    tag_data_o <= tag_mem[tag_addr_i];
    if (state_q == BS_EXEC && cmd_q.found) begin
      if (cmd_q.req.func == FUNC_ESTABLISH) begin
        tag_mem[cmd_q.slot] <= new_h;
        ctx_mem[cmd_q.slot] <= {(cmd_q.req.conf_flag ? SvcPriv :
                                 (cmd_q.req.integ_flag ? SvcInteg : SvcNone)),
                                32'd0, 64'd0};
      end else if (ctx_we) begin
        ctx_mem[cmd_q.slot] <= ctx_wr;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/security_context_replay_window.sv @@
`default_nettype none
// Security context table with 64-entry anti-replay windows. One request at
// a time: the front end walks the table one slot a cycle (valid flags for
// establish, the handle memory for validate/destroy) until it finds a free
// slot or a matching handle or passes the last of the 256 contexts; the back
// end then does one read-modify-write of the context memory. No clearing
// pass: valid flags reset at once.
module security_context_replay_window import scrw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);

  logic [NumContexts-1:0] slot_valid;
  logic [IdxW-1:0] tag_addr;
  logic [31:0]     tag_data;
  logic            cmd_valid, cmd_full, back_busy;
  cmd_t            cmd;

  scrw_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .slot_valid_i(slot_valid), .tag_addr_o(tag_addr), .tag_data_i(tag_data),
    .cmd_valid_o(cmd_valid), .cmd_full_i(cmd_full), .cmd_o(cmd),
    .back_busy_i(back_busy)
  );

  scrw_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_full_o(cmd_full),
    .cmd_i(cmd), .slot_valid_o(slot_valid), .tag_addr_i(tag_addr),
    .tag_data_o(tag_data), .busy_o(back_busy),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
`default_nettype wire

@@ src/scrw_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the top level
module scrw_checker import scrw_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire rsp_t out_data_o
);
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 out_valid_o)
  `ASSERT_ALWAYS(a_status_range, clk_i, rst_ni, !out_valid_o || out_data_o.status <= ST_REPLAY)
  `ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `ASSERT_IMPL(a_grant_ok, clk_i, rst_ni, out_valid_o && out_data_o.granted_service != 2'd0, out_data_o.status == ST_OK)
endmodule

bind security_context_replay_window scrw_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import scrw_pkg::*;

  localparam int unsigned MaxCycles = 4000000;
  localparam int unsigned RandItems = 1000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;

  security_context_replay_window uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Context table mirror
  logic        ctx_valid [NumContexts];
  logic [31:0] ctx_hdl   [NumContexts];
  logic [1:0]  ctx_svc   [NumContexts];
  logic [31:0] ctx_bottom[NumContexts];
  logic [63:0] ctx_seen  [NumContexts];

  rsp_t        pending_rsp[$];
  int          mismatches;
  int          cycle_cnt = 0;
  bit          stim_done;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int lookup_ctx(logic [31:0] h);
    for (int i = 0; i < NumContexts; i++) begin
      if (ctx_valid[i] && ctx_hdl[i] == h) return i;
    end
    return -1;
  endfunction

  // Apply one request to the mirror, return the response it should give
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    int          s;
    logic [31:0] off;
    logic [63:0] bitm;
    o = '0;
    o.status = ST_UNKNOWN;
    case (func_e'(r.func))
      FUNC_ESTABLISH: begin
        s = -1;
        for (int i = 0; i < NumContexts; i++) begin
          if (!ctx_valid[i] && s < 0) s = i;
        end
        if (s < 0) begin
          o.status = ST_FULL;
        end else begin
          ctx_valid[s] = 1'b1;
          ctx_hdl[s] = (r.handle == 0) ? 32'd1 : r.handle;
          ctx_svc[s] = r.conf_flag ? SvcPriv : (r.integ_flag ? SvcInteg : SvcNone);
          ctx_bottom[s] = '0;
          ctx_seen[s] = '0;
          o.status = ST_OK;
          o.stored_handle = ctx_hdl[s];
        end
      end
      FUNC_VALIDATE: begin
        s = lookup_ctx(r.handle);
        if (s >= 0) begin
          if (r.seq_num <= ctx_bottom[s]) begin
            o.status = ST_BELOW;
          end else begin
            off = r.seq_num - ctx_bottom[s];
            if (off > WinSize) begin
              if (off - WinSize >= WinSize) ctx_seen[s] = '0;
              else ctx_seen[s] = ctx_seen[s] >> (off - WinSize);
              ctx_bottom[s] = r.seq_num - WinSize;
              off = WinSize;
            end
            bitm = 64'd1 << (off - 1);
            if ((ctx_seen[s] & bitm) != 0) begin
              o.status = ST_REPLAY;
            end else begin
              ctx_seen[s] |= bitm;
              o.status = ST_OK;
              o.granted_service = (r.req_service > ctx_svc[s]) ? ctx_svc[s] : r.req_service;
            end
          end
        end
      end
      FUNC_DESTROY: begin
        s = lookup_ctx(r.handle);
        if (s >= 0) begin
          ctx_valid[s] = 1'b0;
          ctx_hdl[s] = '0;
          ctx_svc[s] = '0;
          ctx_bottom[s] = '0;
          ctx_seen[s] = '0;
          o.status = ST_OK;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Directed rows; chk marks a hand-typed expected response
  typedef struct {
    req_t r;
    bit   chk;
    rsp_t e;
  } row_t;

  row_t rows[$];

  function automatic req_t mk(func_e f, logic [31:0] h, logic [31:0] q,
                              logic [1:0] rs, logic c, logic g);
    req_t r;
    r.func = f; r.handle = h; r.seq_num = q;
    r.req_service = rs; r.conf_flag = c; r.integ_flag = g;
    return r;
  endfunction

  function automatic rsp_t rs_of(status_e s, logic [1:0] g, logic [31:0] h);
    rsp_t o;
    o.status = s; o.granted_service = g; o.stored_handle = h;
    return o;
  endfunction

  task automatic add_row(req_t r, bit c, rsp_t e);
    row_t w;
    w.r = r; w.chk = c; w.e = e;
    rows.push_back(w);
  endtask

  // Pool of recently used handles for random traffic
  logic [31:0] handle_pool[$];

  function automatic req_t rand_request();
    req_t        r;
    int unsigned k;
    r = '0;
    r.seq_num = $urandom;
    r.req_service = 2'($urandom_range(0, 3));
    r.conf_flag = 1'($urandom_range(0, 1));
    r.integ_flag = 1'($urandom_range(0, 1));
    k = $urandom_range(0, 99);
    if (handle_pool.size() > 0 && $urandom_range(0, 9) != 0)
      r.handle = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
    else
      r.handle = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    if (k < 15) r.func = FUNC_ESTABLISH;
    else if (k < 88) r.func = FUNC_VALIDATE;
    else if (k < 97) r.func = FUNC_DESTROY;
    else r.func = FUNC_UNUSED;
    // Mostly small sequence numbers near the window
    if (k < 80 && $urandom_range(0, 3) != 0) r.seq_num = $urandom_range(0, 400);
    if (r.func == FUNC_ESTABLISH) begin
      if (handle_pool.size() < 12) handle_pool.push_back(r.handle == 0 ? 32'd1 : r.handle);
      else handle_pool[$urandom_range(0, 11)] = (r.handle == 0) ? 32'd1 : r.handle;
    end
    return r;
  endfunction

  // One transaction into the block; idles drawn per item.
  // Valid stays high after acceptance unless an idle gap follows.
  task automatic send_request(req_t r, bit chk, rsp_t e);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (chk) begin
      void'(apply_request(r));
      pending_rsp.push_back(e);
    end else begin
      pending_rsp.push_back(apply_request(r));
    end
  endtask

  // Receiver stall generator: per result, draw a stall length
  initial begin
    int unsigned st;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      st = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (st != 0) begin
        out_stall_i <= 1'b1;
        repeat (st) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", out_data_o);
      end else begin
        e = pending_rsp.pop_front();
        if (out_data_o.status !== e.status || out_data_o.granted_service !== e.granted_service
            || out_data_o.stored_handle !== e.stored_handle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d svc=%0d h=%h got st=%0d svc=%0d h=%h",
                     e.status, e.granted_service, e.stored_handle, out_data_o.status,
                     out_data_o.granted_service, out_data_o.stored_handle);
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rsp_t nx;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    mismatches = 0;
    stim_done = 1'b0;
    for (int i = 0; i < NumContexts; i++) begin
      ctx_valid[i] = 1'b0; ctx_hdl[i] = '0; ctx_svc[i] = '0;
      ctx_bottom[i] = '0; ctx_seen[i] = '0;
    end
    nx = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, zero handle, services, window edges, replays
    add_row(mk(FUNC_VALIDATE, 32'hFFFF_FFFF, 32'd5, 2'd3, 1'b0, 1'b0), 1'b1,
            rs_of(ST_UNKNOWN, 2'd0, 32'd0));
    add_row(mk(FUNC_DESTROY, 32'd0, 32'd0, 2'd0, 1'b0, 1'b0), 1'b1,
            rs_of(ST_UNKNOWN, 2'd0, 32'd0));
    add_row(mk(FUNC_ESTABLISH, 32'd0, 32'd0, 2'd0, 1'b0, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd0, 32'd1));
    add_row(mk(FUNC_ESTABLISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1), 1'b1,
            rs_of(ST_OK, 2'd0, 32'hFFFF_FFFF));
    add_row(mk(FUNC_ESTABLISH, 32'h0000_00AA, 32'd0, 2'd3, 1'b0, 1'b1), 1'b1,
            rs_of(ST_OK, 2'd0, 32'hAA));
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd0, 2'd3, 1'b0, 1'b0), 1'b1,
            rs_of(ST_BELOW, 2'd0, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd1, 2'd3, 1'b0, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd1, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd1, 2'd3, 1'b0, 1'b0), 1'b1,
            rs_of(ST_REPLAY, 2'd0, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd64, 2'd0, 1'b0, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd0, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd65, 2'd2, 1'b0, 1'b0), 1'b0, nx);
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd1, 2'd2, 1'b0, 1'b0), 1'b1,
            rs_of(ST_BELOW, 2'd0, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd64, 2'd2, 1'b0, 1'b0), 1'b0, nx);
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'hFFFF_FFFF, 2'd1, 1'b0, 1'b0), 1'b0, nx);
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'hFFFF_FFFE, 2'd1, 1'b0, 1'b0), 1'b0, nx);
    add_row(mk(FUNC_VALIDATE, 32'hFFFF_FFFF, 32'd10, 2'd3, 1'b0, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd3, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'hAA, 32'd10, 2'd3, 1'b0, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd2, 32'd0));
    add_row(mk(FUNC_UNUSED, 32'hAA, 32'd11, 2'd3, 1'b1, 1'b1), 1'b1,
            rs_of(ST_UNKNOWN, 2'd0, 32'd0));
    add_row(mk(FUNC_ESTABLISH, 32'hAA, 32'd0, 2'd0, 1'b1, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd0, 32'hAA));
    add_row(mk(FUNC_DESTROY, 32'hAA, 32'd0, 2'd0, 1'b0, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd0, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'hAA, 32'd10, 2'd3, 1'b0, 1'b0), 1'b0, nx);
    add_row(mk(FUNC_DESTROY, 32'd1, 32'd0, 2'd0, 1'b0, 1'b0), 1'b1,
            rs_of(ST_OK, 2'd0, 32'd0));
    add_row(mk(FUNC_VALIDATE, 32'd1, 32'd3, 2'd3, 1'b0, 1'b0), 1'b1,
            rs_of(ST_UNKNOWN, 2'd0, 32'd0));
    foreach (rows[i]) send_request(rows[i].r, rows[i].chk, rows[i].e);
    in_valid_i <= 1'b0;

    // Hold off until all pending responses have been checked
    while (pending_rsp.size() != 0) @(posedge clk_i);

    // Fill the table to overflow, then random traffic
    for (int i = 0; i < NumContexts + 2; i++)
      send_request(mk(FUNC_ESTABLISH, $urandom, 32'd0, 2'd0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1))), 1'b0, nx);
    for (int i = 0; i < RandItems; i++) begin
      // Periodically free many slots so establish keeps succeeding
      if (i % 400 == 0) begin
        for (int j = 0; j < NumContexts; j++) begin
          if (ctx_valid[j] && $urandom_range(0, 1) == 0)
            send_request(mk(FUNC_DESTROY, ctx_hdl[j], $urandom, 2'd0, 1'b0, 1'b0), 1'b0, nx);
        end
      end
      send_request(rand_request(), 1'b0, nx);
    end
    in_valid_i <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
